// ===== rtl/c8ie_pkg.sv =====
// ----------------------------------------------------------------------------
// c8ie_pkg
// Shared types and constants for the instruction execute unit.
// ----------------------------------------------------------------------------
package c8ie_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned AddrWidthDef  = 12;
  localparam int unsigned OutAddrWidth  = 12;
  localparam logic [11:0] StartAddr     = 12'h200;

  localparam logic [15:0] InsCls = 16'h00E0;
  localparam logic [15:0] InsRet = 16'h00EE;
  localparam logic [3:0]  RegFlag = 4'hF;
  localparam logic [3:0]  RegZero = 4'h0;

  typedef enum logic [3:0] {
    OP_SYS     = 4'h0,
    OP_JP      = 4'h1,
    OP_CALL    = 4'h2,
    OP_SE_IMM  = 4'h3,
    OP_SNE_IMM = 4'h4,
    OP_SE_REG  = 4'h5,
    OP_LD_IMM  = 4'h6,
    OP_ADD_IMM = 4'h7,
    OP_ALU     = 4'h8,
    OP_SNE_REG = 4'h9,
    OP_LD_I    = 4'hA,
    OP_JP_V0   = 4'hB,
    OP_RND     = 4'hC,
    OP_DRW     = 4'hD,
    OP_SKP     = 4'hE,
    OP_MISC    = 4'hF
  } op_e;

  typedef enum logic [3:0] {
    ALU_MOV  = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_e;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_UNKNOWN   = 2'd1,
    FAULT_OVERFLOW  = 2'd2,
    FAULT_UNDERFLOW = 2'd3
  } fault_e;

endpackage

// ===== rtl/chip8_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// Executes one fetched instruction word per input word and reports next PC,
// I, the register write, VF, clear screen and a fault code.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  instruction_i, random_byte_i
//   out      output     out_valid_o/out_ready_i next_pc_o .. fault_o
//   cfg      input      cfg_we_i               cfg_wdata_i (start address)
//
// one word per cycle sustained while the output is taken; the result is valid once executed
// (register and stack memory read at the accepting edge, then execute into the output register)
// reset: PC = 0x200, I and V registers zero, stack empty; the start address
// register never sets PC, and reset restores it to 0x200
// a full output register stalls execute, and execute stalls input
// ----------------------------------------------------------------------------
module chip8_instruction_execute #(
  parameter int unsigned STACK_DEPTH = c8ie_pkg::StackDepthDef,
  parameter int unsigned ADDR_WIDTH  = c8ie_pkg::AddrWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] instruction_i,
  input  logic [7:0]  random_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] next_pc_o,
  output logic [11:0] index_value_o,
  output logic        reg_written_o,
  output logic [3:0]  reg_number_o,
  output logic [7:0]  reg_value_o,
  output logic [7:0]  flag_value_o,
  output logic        clear_display_o,
  output c8ie_pkg::fault_e fault_o
);
  import c8ie_pkg::*;

  localparam int unsigned LvlW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SpW  = $clog2(STACK_DEPTH);
  localparam int unsigned AW   = ADDR_WIDTH;

  // start address register
  logic [11:0] start_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartAddr;
    end else if (cfg_we_i) begin
      start_q <= cfg_wdata_i;
    end
  end

  // control
  logic s1_valid_q, out_valid_q, s1_go, accept;
  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign accept     = in_valid_i && in_ready_o;

  // architectural flip-flop state
  logic [AW-1:0]   pc_q, pc_d, idx_q, idx_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic [7:0]      vf_q, vf_d;
  logic [15:0]     vvalid_q;

  // execute stage word
  logic [15:0]    ins_q;
  logic [7:0]     rnd_q;
  logic [3:0]     rb_addr_q;
  logic [SpW-1:0] sp_raddr_q;

  // write ports and forwarding captures
  logic           v_we;
  logic [3:0]     v_waddr;
  logic [7:0]     v_wdata;
  logic           s_we;
  logic [SpW-1:0] s_waddr;
  logic [AW-1:0]  s_wdata;
  logic           fv_valid_q, fs_valid_q;
  logic [3:0]     fv_addr_q;
  logic [7:0]     fv_data_q;
  logic [SpW-1:0] fs_addr_q;
  logic [AW-1:0]  fs_data_q;

  // read addresses issued at accept
  logic [3:0]      ra_addr, rb_addr;
  logic [LvlW-1:0] lvl_next, lvl_m1;
  logic [SpW-1:0]  sp_raddr;
  assign ra_addr  = instruction_i[11:8];
  assign rb_addr  = (op_e'(instruction_i[15:12]) == OP_JP_V0) ? RegZero : instruction_i[7:4];
  assign lvl_next = s1_go ? lvl_d : lvl_q;
  assign lvl_m1   = lvl_next - LvlW'(1);
  assign sp_raddr = lvl_m1[SpW-1:0];

  logic [7:0]    ram_a, ram_b;
  logic [AW-1:0] ram_s;

  c8ie_ram #(.Width(8), .Depth(16)) u_vram_a (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .re_i(accept), .raddr_i(ra_addr), .rdata_o(ram_a)
  );

  c8ie_ram #(.Width(8), .Depth(16)) u_vram_b (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .re_i(accept), .raddr_i(rb_addr), .rdata_o(ram_b)
  );

  c8ie_ram #(.Width(AW), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(s1_go && s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(accept), .raddr_i(sp_raddr), .rdata_o(ram_s)
  );

  // operand selection: VF from its flip-flop, same-cycle writes forwarded
  logic [3:0]    x;
  logic [7:0]    nn, vx, vb;
  logic [AW-1:0] ret_addr;
  assign x  = ins_q[11:8];
  assign nn = ins_q[7:0];

  always_comb begin
    if (x == RegFlag) begin
      vx = vf_q;
    end else if (fv_valid_q && fv_addr_q == x) begin
      vx = fv_data_q;
    end else begin
      vx = vvalid_q[x] ? ram_a : 8'h00;
    end
    if (rb_addr_q == RegFlag) begin
      vb = vf_q;
    end else if (fv_valid_q && fv_addr_q == rb_addr_q) begin
      vb = fv_data_q;
    end else begin
      vb = vvalid_q[rb_addr_q] ? ram_b : 8'h00;
    end
    ret_addr = (fs_valid_q && fs_addr_q == sp_raddr_q) ? fs_data_q : ram_s;
  end

  // execute
  logic [AW-1:0] pc2, pc4, nnn;
  logic          wr, wflag, clr;
  logic [7:0]    res, flag, res_fin;
  logic [8:0]    sum;
  fault_e        fault;
  assign pc2 = pc_q + AW'(2);
  assign pc4 = pc_q + AW'(4);
  assign nnn = AW'(ins_q[11:0]);
  assign sum = {1'b0, vx} + {1'b0, vb};

  always_comb begin
    pc_d  = pc_q;
    idx_d = idx_q;
    lvl_d = lvl_q;
    wr    = 1'b0;
    wflag = 1'b0;
    clr   = 1'b0;
    res   = 8'h00;
    flag  = 8'h00;
    fault = FAULT_NONE;
    s_we  = 1'b0;
    case (op_e'(ins_q[15:12]))
      OP_SYS: begin
        if (ins_q == InsCls) begin
          clr  = 1'b1;
          pc_d = pc2;
        end else if (ins_q == InsRet) begin
          if (lvl_q == '0) begin
            fault = FAULT_UNDERFLOW;
          end else begin
            lvl_d = lvl_q - LvlW'(1);
            pc_d  = ret_addr + AW'(2);
          end
        end else begin
          fault = FAULT_UNKNOWN;
        end
      end
      OP_JP:      pc_d = nnn;
      OP_CALL: begin
        if (lvl_q >= LvlW'(STACK_DEPTH)) begin
          fault = FAULT_OVERFLOW;
        end else begin
          s_we  = 1'b1;
          lvl_d = lvl_q + LvlW'(1);
          pc_d  = nnn;
        end
      end
      OP_SE_IMM:  pc_d = (vx == nn) ? pc4 : pc2;
      OP_SNE_IMM: pc_d = (vx != nn) ? pc4 : pc2;
      OP_SE_REG:  pc_d = (vx == vb) ? pc4 : pc2;
      OP_LD_IMM: begin
        wr   = 1'b1;
        res  = nn;
        pc_d = pc2;
      end
      OP_ADD_IMM: begin
        wr   = 1'b1;
        res  = vx + nn;
        pc_d = pc2;
      end
      OP_ALU: begin
        pc_d = pc2;
        wr   = 1'b1;
        case (alu_e'(ins_q[3:0]))
          ALU_MOV: res = vb;
          ALU_OR:  res = vx | vb;
          ALU_AND: res = vx & vb;
          ALU_XOR: res = vx ^ vb;
          ALU_ADD: begin
            res   = sum[7:0];
            flag  = {7'd0, sum[8]};
            wflag = 1'b1;
          end
          ALU_SUB: begin
            res   = vx - vb;
            flag  = {7'd0, vb <= vx};
            wflag = 1'b1;
          end
          ALU_SHR: begin
            res   = {1'b0, vx[7:1]};
            flag  = {7'd0, vx[0]};
            wflag = 1'b1;
          end
          ALU_SUBN: begin
            res   = vb - vx;
            flag  = {7'd0, vx <= vb};
            wflag = 1'b1;
          end
          ALU_SHL: begin
            res   = {vx[6:0], 1'b0};
            flag  = {7'd0, vx[7]};
            wflag = 1'b1;
          end
          default: begin
            wr    = 1'b0;
            fault = FAULT_UNKNOWN;
            pc_d  = pc_q;
          end
        endcase
      end
      OP_SNE_REG: pc_d = (vx != vb) ? pc4 : pc2;
      OP_LD_I: begin
        idx_d = nnn;
        pc_d  = pc2;
      end
      OP_JP_V0:   pc_d = nnn + AW'(vb);
      OP_RND: begin
        wr   = 1'b1;
        res  = rnd_q & nn;
        pc_d = pc2;
      end
      default:    fault = FAULT_UNKNOWN;
    endcase
  end

  assign res_fin = (wflag && x == RegFlag) ? flag : res;
  assign vf_d    = wflag ? flag : ((wr && x == RegFlag) ? res : vf_q);
  assign v_we    = s1_go && wr && (x != RegFlag);
  assign v_waddr = x;
  assign v_wdata = res;
  assign s_waddr = lvl_q[SpW-1:0];
  assign s_wdata = pc_q;

  // sequential
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= AW'(StartAddr);
      idx_q       <= '0;
      lvl_q       <= '0;
      vf_q        <= 8'h00;
      vvalid_q    <= '0;
      fv_valid_q  <= 1'b0;
      fs_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_go) begin
        pc_q  <= pc_d;
        idx_q <= idx_d;
        lvl_q <= lvl_d;
        vf_q  <= vf_d;
      end
      if (v_we) begin
        vvalid_q[v_waddr] <= 1'b1;
      end
      if (accept) begin
        fv_valid_q <= v_we;
        fs_valid_q <= s1_go && s_we;
      end
    end
  end

  logic [11:0] pc_out_q, idx_out_q;
  logic        wr_out_q, clr_out_q;
  logic [3:0]  num_out_q;
  logic [7:0]  val_out_q, vf_out_q;
  fault_e      fault_out_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ins_q      <= instruction_i;
      rnd_q      <= random_byte_i;
      rb_addr_q  <= rb_addr;
      sp_raddr_q <= sp_raddr;
      fv_addr_q  <= v_waddr;
      fv_data_q  <= v_wdata;
      fs_addr_q  <= s_waddr;
      fs_data_q  <= s_wdata;
    end
    if (s1_go) begin
      pc_out_q    <= pc_d[OutAddrWidth-1:0];
      idx_out_q   <= idx_d[OutAddrWidth-1:0];
      wr_out_q    <= wr;
      num_out_q   <= wr ? x : 4'd0;
      val_out_q   <= wr ? res_fin : 8'h00;
      vf_out_q    <= vf_d;
      clr_out_q   <= clr;
      fault_out_q <= fault;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign next_pc_o       = pc_out_q;
  assign index_value_o   = idx_out_q;
  assign reg_written_o   = wr_out_q;
  assign reg_number_o    = num_out_q;
  assign reg_value_o     = val_out_q;
  assign flag_value_o    = vf_out_q;
  assign clear_display_o = clr_out_q;
  assign fault_o         = fault_out_q;

  // start address register is not used; reset reloads it
  logic unused_start;
  assign unused_start = ^start_q;

  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LvlW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_fault_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && fault != FAULT_NONE) |=> (pc_q == $past(pc_q) && lvl_q == $past(lvl_q)))
    else $error("faulting word changed state");

  a_no_vf_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_we |-> (v_waddr != RegFlag))
    else $error("VF written to register memory");

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |-> !in_ready_o)
    else $error("input taken while execute stalled");

  a_out_follows_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |=> out_valid_o)
    else $error("executed word lost");

endmodule

// ===== rtl/c8ie_ram.sv =====
// ----------------------------------------------------------------------------
// c8ie_ram
// Generic RAM, one write port and one read port, registered read data.
// A read and a write of the same entry in one cycle return the old data.
// ----------------------------------------------------------------------------
module c8ie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
